FILE: src/mrbf_pkg.sv
// ----------------------------------------------------------------------------
// mrbf_pkg: shared types and constants of the multiquadric RBF evaluator
// Register map, sequencer states, the configuration bundle and saturation.
// ----------------------------------------------------------------------------
package mrbf_pkg;

	localparam int DEF_NUM_CENTERS = 64;
	localparam int DEF_NUM_AXES    = 4;
	localparam int FIELD_AXES      = 4;
	localparam int PADDR_W         = 5;
	localparam int SQRT_STEPS      = 32;
	localparam int DIV_STEPS       = 47;

	typedef enum logic [2:0] {
		REG_SHAPE_C      = 3'd0,
		REG_INV_C        = 3'd1,
		REG_CENTERS_USED = 3'd2,
		REG_DIMS_USED    = 3'd3,
		REG_INV_SCALE_0  = 3'd4,
		REG_INV_SCALE_1  = 3'd5,
		REG_INV_SCALE_2  = 3'd6,
		REG_INV_SCALE_3  = 3'd7
	} reg_idx_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_EVAL = 1'b1
	} opcode_t;

	typedef struct packed {
		logic [30:0]                  shape_c;
		logic [30:0]                  inv_c;
		logic [6:0]                   centers_used;
		logic [2:0]                   dims_used;
		logic [FIELD_AXES-1:0][30:0] inv_scale;
	} cfg_t;

	// Control bundle from the sequencer to the root / divide unit.
	typedef struct packed {
		logic start;
		logic is_div;
	} rd_ctl_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_Q_MUL,
		ST_Q_WB,
		ST_C_START,
		ST_C_RD,
		ST_U_MUL,
		ST_U_WB,
		ST_SQ_MUL,
		ST_SQ_WB,
		ST_SQRT_GO,
		ST_SQRT,
		ST_CS_MUL,
		ST_CS_WB,
		ST_VT_MUL,
		ST_VT_WB,
		ST_DIV_GO,
		ST_DIV,
		ST_SL_MUL,
		ST_SL_WB,
		ST_NEXT,
		ST_FIN_V,
		ST_FIN_S,
		ST_OUT
	} state_t;

	// Saturate a wide signed value to 32 bits; the top bit flags a clip.
	function automatic logic [32:0] sat32(input logic signed [66:0] v);
		logic [32:0] r;
		if (v > 67'sd2147483647) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < -67'sd2147483648) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

endpackage

FILE: src/mrbf_ifs.sv
// ----------------------------------------------------------------------------
// mrbf_ifs: word channels of the RBF evaluator
// Input item channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mrbf_item_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic [5:0]         center_index;
	logic signed [31:0] coord_0;
	logic signed [31:0] coord_1;
	logic signed [31:0] coord_2;
	logic signed [31:0] coord_3;
	logic signed [31:0] weight;
	logic [1:0]         slope_axis;

	modport source (output valid, opcode, center_index, coord_0, coord_1, coord_2,
		coord_3, weight, slope_axis, input ready);
	modport sink (input valid, opcode, center_index, coord_0, coord_1, coord_2,
		coord_3, weight, slope_axis, output ready);
endinterface

interface mrbf_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic signed [31:0] slope;
	logic               saturated;

	modport source (output valid, value, slope, saturated, input ready);
	modport sink (input valid, value, slope, saturated, output ready);
endinterface

FILE: src/multiquadric_rbf_evaluator_unit.sv
// ----------------------------------------------------------------------------
// multiquadric_rbf_evaluator_unit: multiquadric RBF interpolator, Q16.16
// Stores centers and weights and evaluates the interpolant and one slope.
// ----------------------------------------------------------------------------
// A load word writes one center row (coordinates and weight) and produces
// no result. An evaluate word scales the query per axis, then walks the
// centers in use one at a time through one shared multiplier and one
// bit-serial root/divide unit: a square root per center, plus the 47-step
// divide when the slope axis is in use, and ends with the final slope
// scaling. The input channel is not ready from the evaluate word until its
// result is taken.
// The center memory holds undefined data after reset and needs no clearing.
// ----------------------------------------------------------------------------
module multiquadric_rbf_evaluator_unit #(
	parameter int NUM_CENTERS = mrbf_pkg::DEF_NUM_CENTERS,
	parameter int NUM_AXES    = mrbf_pkg::DEF_NUM_AXES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mrbf_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	mrbf_item_if.sink                    cmd,
	mrbf_result_if.source                res
);
	import mrbf_pkg::*;

	localparam int AW     = (NUM_CENTERS > 1) ? $clog2(NUM_CENTERS) : 1;
	localparam int CW     = $clog2(NUM_CENTERS + 1);
	localparam int ROW_W  = (NUM_AXES + 1) * 32;
	localparam int AX_MAX = (NUM_AXES < FIELD_AXES) ? NUM_AXES : FIELD_AXES;

	cfg_t cfg;

	mrbf_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg
	);

	state_t state_q, state_d;

	// Per-evaluation registers.
	logic signed [31:0] crd_q [FIELD_AXES];
	logic signed [31:0] q_q   [FIELD_AXES];
	logic [1:0]         ax_q;
	logic [2:0]         nd_q, k_q;
	logic [CW-1:0]      nc_q, ci_q;
	logic [ROW_W-1:0]   row_q;
	logic [63:0]        r_q, acc_v_q, acc_d_q;
	logic signed [31:0] u_q, ud_q, ratio_q, sd_q;
	logic [31:0]        s_q, cs_q;
	logic               flag_q;
	logic signed [31:0] value_q, slope_q;

	logic has_slope;
	assign has_slope = ({1'b0, ax_q} < nd_q);

	// Memory: one row per center, coordinates low, weight on top.
	logic             ram_we;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [ROW_W-1:0] ram_wdata, ram_rdata;

	mrbf_ram #(.WIDTH(ROW_W), .DEPTH(NUM_CENTERS)) u_ram (
		.clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	logic signed [31:0] cin [FIELD_AXES];
	assign cin[0] = cmd.coord_0;
	assign cin[1] = cmd.coord_1;
	assign cin[2] = cmd.coord_2;
	assign cin[3] = cmd.coord_3;

	always_comb begin
		ram_wdata = '0;
		for (int k = 0; k < NUM_AXES; k++) begin
			if (k < FIELD_AXES) begin
				ram_wdata[k*32 +: 32] = cin[k];
			end
		end
		ram_wdata[NUM_AXES*32 +: 32] = cmd.weight;
	end

	assign ram_waddr = AW'(cmd.center_index);
	assign ram_raddr = ci_q[AW-1:0];

	// Shared multiplier.
	logic signed [33:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [66:0] prod;
	logic signed [66:0] prod_sh;

	mrbf_mul u_mul (.clk, .a(mul_a), .b(mul_b), .prod_q(prod));

	// Floor of the product divided by 2^16.
	assign prod_sh = prod >>> 16;

	// Square root / divide unit.
	rd_ctl_t     rd_ctl;
	logic [63:0] rd_src;
	logic        rd_done;
	logic [31:0] rd_res;
	logic [30:0] ud_mag;

	assign ud_mag = ud_q[31] ? 31'(-ud_q) : ud_q[30:0];
	assign rd_src = rd_ctl.is_div ? {ud_mag, 33'd0} : r_q;

	mrbf_rootdiv u_rootdiv (
		.clk, .arst_n, .ctl(rd_ctl), .src(rd_src), .divisor(s_q),
		.done(rd_done), .res(rd_res)
	);

	// Operand views.
	logic signed [31:0] x_k, w_c;
	logic signed [32:0] d_k;
	logic [1:0]         ki;

	assign ki  = k_q[1:0];
	assign x_k = row_q[32*ki +: 32];
	assign w_c = row_q[NUM_AXES*32 +: 32];
	assign d_k = {q_q[ki][31], q_q[ki]} - {x_k[31], x_k};

	logic cmd_fire, res_fire;
	assign cmd_fire = cmd.valid & cmd.ready;
	assign res_fire = res.valid & res.ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (cmd_fire && cmd.opcode == OP_EVAL) state_d = ST_Q_MUL;
			ST_Q_MUL:   state_d = ST_Q_WB;
			ST_Q_WB:    state_d = (k_q == 3'(FIELD_AXES - 1)) ? ST_C_START : ST_Q_MUL;
			ST_C_START: state_d = (ci_q == nc_q) ? ST_FIN_V : ST_C_RD;
			ST_C_RD:    state_d = (nd_q == 3'd0) ? ST_SQRT_GO : ST_U_MUL;
			ST_U_MUL:   state_d = ST_U_WB;
			ST_U_WB:    state_d = ST_SQ_MUL;
			ST_SQ_MUL:  state_d = ST_SQ_WB;
			ST_SQ_WB:   state_d = (k_q + 3'd1 == nd_q) ? ST_SQRT_GO : ST_U_MUL;
			ST_SQRT_GO: state_d = ST_SQRT;
			ST_SQRT:    if (rd_done) state_d = ST_CS_MUL;
			ST_CS_MUL:  state_d = ST_CS_WB;
			ST_CS_WB:   state_d = ST_VT_MUL;
			ST_VT_MUL:  state_d = ST_VT_WB;
			ST_VT_WB:   state_d = has_slope ? ST_DIV_GO : ST_NEXT;
			ST_DIV_GO:  state_d = ST_DIV;
			ST_DIV:     if (rd_done) state_d = ST_SL_MUL;
			ST_SL_MUL:  state_d = ST_SL_WB;
			ST_SL_WB:   state_d = ST_NEXT;
			ST_NEXT:    state_d = ST_C_START;
			ST_FIN_V:   state_d = has_slope ? ST_FIN_S : ST_OUT;
			ST_FIN_S:   state_d = ST_OUT;
			ST_OUT:     if (res_fire) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshakes, memory write, unit controls, operands.
	always_comb begin
		cmd.ready     = 1'b0;
		res.valid     = 1'b0;
		ram_we        = 1'b0;
		rd_ctl.start  = 1'b0;
		rd_ctl.is_div = 1'b0;
		mul_a         = '0;
		mul_b         = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				ram_we    = cmd_fire && cmd.opcode == OP_LOAD &&
					32'(cmd.center_index) < NUM_CENTERS;
			end
			ST_Q_MUL: begin
				mul_a = {{2{crd_q[ki][31]}}, crd_q[ki]};
				mul_b = {2'd0, cfg.inv_scale[ki]};
			end
			ST_U_MUL: begin
				mul_a = {d_k[32], d_k};
				mul_b = {2'd0, cfg.inv_c};
			end
			ST_SQ_MUL: begin
				mul_a = {{2{u_q[31]}}, u_q};
				mul_b = {u_q[31], u_q};
			end
			ST_SQRT_GO: rd_ctl.start = 1'b1;
			ST_CS_MUL: begin
				mul_a = {3'd0, cfg.shape_c};
				mul_b = {1'b0, s_q};
			end
			ST_VT_MUL: begin
				mul_a = {{2{w_c[31]}}, w_c};
				mul_b = {1'b0, cs_q};
			end
			ST_DIV_GO: begin
				rd_ctl.start  = 1'b1;
				rd_ctl.is_div = 1'b1;
			end
			ST_SL_MUL: begin
				mul_a = {{2{w_c[31]}}, w_c};
				mul_b = {ratio_q[31], ratio_q};
			end
			ST_FIN_V: begin
				mul_a = {{2{sd_q[31]}}, sd_q};
				mul_b = {2'd0, cfg.inv_scale[ax_q]};
			end
			ST_OUT: res.valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers.
	logic [32:0] sat_v, sat_d, sat_p;
	assign sat_v = sat32(67'(signed'(acc_v_q)));
	assign sat_d = sat32(67'(signed'(acc_d_q)));
	assign sat_p = sat32(prod_sh);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_fire && cmd.opcode == OP_EVAL) begin
					for (int k = 0; k < FIELD_AXES; k++) begin
						crd_q[k] <= cin[k];
					end
					ax_q    <= cmd.slope_axis;
					k_q     <= '0;
					ci_q    <= '0;
					acc_v_q <= '0;
					acc_d_q <= '0;
					flag_q  <= 1'b0;
					slope_q <= '0;
					if (cfg.dims_used > 3'(AX_MAX)) begin
						nd_q <= 3'(AX_MAX);
					end else begin
						nd_q <= cfg.dims_used;
					end
					if (32'(cfg.centers_used) > NUM_CENTERS) begin
						nc_q <= CW'(NUM_CENTERS);
					end else begin
						nc_q <= CW'(cfg.centers_used);
					end
				end
			end
			ST_Q_WB: begin
				q_q[ki] <= sat_p[31:0];
				if (sat_p[32]) flag_q <= 1'b1;
				k_q <= (k_q == 3'(FIELD_AXES - 1)) ? 3'd0 : k_q + 3'd1;
			end
			ST_C_RD: begin
				row_q <= ram_rdata;
				r_q   <= 64'h1_0000_0000;
				k_q   <= '0;
				ud_q  <= '0;
			end
			ST_U_WB: begin
				// Clip to the symmetric range of 31-bit magnitudes.
				if (prod_sh > 67'sd2147483647) begin
					u_q    <= 32'sh7FFF_FFFF;
					flag_q <= 1'b1;
					if ({1'b0, ax_q} == k_q) ud_q <= 32'sh7FFF_FFFF;
				end else if (prod_sh < -67'sd2147483647) begin
					u_q    <= -32'sh7FFF_FFFF;
					flag_q <= 1'b1;
					if ({1'b0, ax_q} == k_q) ud_q <= -32'sh7FFF_FFFF;
				end else begin
					u_q <= prod_sh[31:0];
					if ({1'b0, ax_q} == k_q) ud_q <= prod_sh[31:0];
				end
			end
			ST_SQ_WB: begin
				r_q <= r_q + prod[63:0];
				k_q <= k_q + 3'd1;
			end
			ST_SQRT: if (rd_done) s_q <= rd_res;
			ST_CS_WB: begin
				if (prod[66:48] != '0) begin
					cs_q   <= 32'hFFFF_FFFF;
					flag_q <= 1'b1;
				end else begin
					cs_q <= prod[47:16];
				end
			end
			ST_VT_WB: acc_v_q <= acc_v_q + prod_sh[63:0];
			ST_DIV: begin
				if (rd_done) begin
					ratio_q <= ud_q[31] ? -signed'(rd_res) : signed'(rd_res);
				end
			end
			ST_SL_WB: acc_d_q <= acc_d_q + prod_sh[63:0];
			ST_NEXT: ci_q <= ci_q + CW'(1);
			ST_C_START: begin
				if (ci_q == nc_q) begin
					value_q <= sat_v[31:0];
					sd_q    <= sat_d[31:0];
					// The slope sum only counts when its axis is in use.
					flag_q  <= flag_q | sat_v[32] | (has_slope & sat_d[32]);
				end
			end
			ST_FIN_S: begin
				slope_q <= sat_p[31:0];
				if (sat_p[32]) flag_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign res.value     = value_q;
	assign res.slope     = slope_q;
	assign res.saturated = flag_q;
endmodule

FILE: src/mrbf_ram.sv
// ----------------------------------------------------------------------------
// mrbf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mrbf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic             clk,
	input  logic             we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: src/mrbf_regs.sv
// ----------------------------------------------------------------------------
// mrbf_regs: configuration registers
// APB-style register file holding shape, scale and count settings.
// ----------------------------------------------------------------------------
module mrbf_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mrbf_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output mrbf_pkg::cfg_t               cfg
);
	import mrbf_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shape_c      <= 31'd65536;
			cfg_q.inv_c        <= 31'd65536;
			cfg_q.centers_used <= 7'd64;
			cfg_q.dims_used    <= 3'd4;
			cfg_q.inv_scale    <= {FIELD_AXES{31'd65536}};
		end else if (wr) begin
			unique case (idx)
				REG_SHAPE_C:      cfg_q.shape_c      <= pwdata[30:0];
				REG_INV_C:        cfg_q.inv_c        <= pwdata[30:0];
				REG_CENTERS_USED: cfg_q.centers_used <= pwdata[6:0];
				REG_DIMS_USED:    cfg_q.dims_used    <= pwdata[2:0];
				REG_INV_SCALE_0:  cfg_q.inv_scale[0] <= pwdata[30:0];
				REG_INV_SCALE_1:  cfg_q.inv_scale[1] <= pwdata[30:0];
				REG_INV_SCALE_2:  cfg_q.inv_scale[2] <= pwdata[30:0];
				REG_INV_SCALE_3:  cfg_q.inv_scale[3] <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_SHAPE_C:      prdata = {1'b0, cfg_q.shape_c};
			REG_INV_C:        prdata = {1'b0, cfg_q.inv_c};
			REG_CENTERS_USED: prdata = {25'd0, cfg_q.centers_used};
			REG_DIMS_USED:    prdata = {29'd0, cfg_q.dims_used};
			REG_INV_SCALE_0:  prdata = {1'b0, cfg_q.inv_scale[0]};
			REG_INV_SCALE_1:  prdata = {1'b0, cfg_q.inv_scale[1]};
			REG_INV_SCALE_2:  prdata = {1'b0, cfg_q.inv_scale[2]};
			REG_INV_SCALE_3:  prdata = {1'b0, cfg_q.inv_scale[3]};
			default:          prdata = 32'd0;
		endcase
	end
endmodule

FILE: src/mrbf_mul.sv
// ----------------------------------------------------------------------------
// mrbf_mul: shared signed multiplier
// 34 x 33 bit signed multiply with a registered product.
// ----------------------------------------------------------------------------
module mrbf_mul (
	input  logic               clk,
	input  logic signed [33:0] a,
	input  logic signed [32:0] b,
	output logic signed [66:0] prod_q
);
	always_ff @(posedge clk) begin
		prod_q <= 67'(a * b);
	end
endmodule

FILE: src/mrbf_rootdiv.sv
// ----------------------------------------------------------------------------
// mrbf_rootdiv: bit-serial square root and divide unit
// One compare-subtract per cycle serves both the integer square root of a
// 64-bit radicand and an unsigned long division by a 32-bit divisor.
// ----------------------------------------------------------------------------
module mrbf_rootdiv (
	input  logic              clk,
	input  logic              arst_n,
	input  mrbf_pkg::rd_ctl_t ctl,
	input  logic [63:0]       src,
	input  logic [31:0]       divisor,
	output logic              done,
	output logic [31:0]       res
);
	import mrbf_pkg::*;

	logic        busy_q, is_div_q, done_q;
	logic [5:0]  cnt_q;
	logic [63:0] src_q;
	logic [35:0] rem_q;
	logic [31:0] res_q, div_q;
	logic [35:0] opa, opb;
	logic        ge;
	logic [5:0]  last;

	always_comb begin
		if (is_div_q) begin
			opa  = {rem_q[34:0], src_q[63]};
			opb  = {4'd0, div_q};
			last = 6'(DIV_STEPS - 1);
		end else begin
			opa  = {rem_q[33:0], src_q[63:62]};
			opb  = {2'd0, res_q, 2'b01};
			last = 6'(SQRT_STEPS - 1);
		end
		ge = (opa >= opb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			is_div_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q   <= 1'b1;
				is_div_q <= ctl.is_div;
				cnt_q    <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			src_q <= src;
			div_q <= divisor;
			rem_q <= '0;
			res_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (opa - opb) : opa;
			res_q <= {res_q[30:0], ge};
			src_q <= is_div_q ? {src_q[62:0], 1'b0} : {src_q[61:0], 2'b00};
		end
	end

	assign done = done_q;
	assign res  = res_q;
endmodule
